>>> hdl/bol_pkg.sv
// Shared types and codes for the bounded ordered list.
// No dependencies; used by bol_ram and bounded_ordered_list.
package bol_pkg;

    // One stored list entry / request value
    typedef logic signed [31:0] t_word;

    typedef logic [2:0] t_action;
    typedef logic [1:0] t_status;

    localparam t_action ACT_APPEND = 3'd0;
    localparam t_action ACT_HEAD   = 3'd1;
    localparam t_action ACT_SEARCH = 3'd2;
    localparam t_action ACT_DELETE = 3'd3;
    localparam t_action ACT_SUM    = 3'd4;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NOTFOUND = 2'd1;
    localparam t_status ST_FULL     = 2'd2;

endpackage

>>> hdl/bol_ram.sv
// Entry store for the bounded ordered list: one write port, one read port,
// registered read data. Depends on bol_pkg for the entry type.
module bol_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  bol_pkg::t_word   i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output bol_pkg::t_word   o_rdata
);

    bol_pkg::t_word r_mem [DEPTH];
    bol_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bounded_ordered_list.sv
// Bounded ordered list: sequencer, length and running-sum registers.
// Depends on bol_pkg (types, codes) and bol_ram (entry store).
//
//   channel  dir  tdata (low bit up)                       tuser
//   s        in   value[31:0]                              action[2:0]
//   m        out  position, total[31:0], entry_count, pad  status[1:0]
//
// Append, sum and refused inserts go from accept straight to the done state.
// Head insert, search and delete walk the entries (delete scans to the match,
// then closes up the tail) through the entry store's single read port, one
// entry read per cycle.
// Reset (synchronous, active low) empties the list and clears the sum; the
// entry store is not cleared, only entries below the length are ever read.
// A request is taken only while the sequencer is idle; a finished result
// waiting on the m side does not block the next request, but that request
// holds in the done state until the output register frees up.
module bounded_ordered_list #(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // value (signed)
    input  logic [2:0]  i_s_tuser,   // action

    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // position, total, entry_count, zero pad (from bit 0 up)
    output logic [((2*$clog2(CAPACITY+1)+32+7)/8)*8-1:0] o_m_tdata,
    output logic [1:0]                               o_m_tuser   // status
);

    localparam int LW  = $clog2(CAPACITY + 1);           // length / position width
    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TDW = ((2*LW + 32 + 7) / 8) * 8;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;  // walk entries looking for a match
    localparam logic [2:0] S_SHUP = 3'd2;  // move entries one slot toward the tail
    localparam logic [2:0] S_SHDN = 3'd3;  // close up after a delete
    localparam logic [2:0] S_DONE = 3'd4;  // hand the result to the output register

    logic [2:0]               r_state, n_state;
    logic [LW-1:0]            r_len, n_len;
    bol_pkg::t_word           r_sum, n_sum;
    bol_pkg::t_action         r_act, n_act;
    bol_pkg::t_word           r_val, n_val;
    logic [AW-1:0]            r_idx, n_idx;     // next read address
    logic                     r_more, n_more;   // reads still to issue
    logic                     r_pend, n_pend;   // read data arrives this cycle
    logic [AW-1:0]            r_pidx, n_pidx;   // address of arriving data
    bol_pkg::t_status         r_status, n_status;
    logic [LW-1:0]            r_pos, n_pos;

    logic                     r_ovalid, n_ovalid;
    bol_pkg::t_status         r_ostatus, n_ostatus;
    logic [LW-1:0]            r_opos, n_opos;
    bol_pkg::t_word           r_ototal, n_ototal;
    logic [LW-1:0]            r_ocount, n_ocount;

    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    bol_pkg::t_word           rd_data;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    bol_pkg::t_word           wr_data;

    logic                     full;
    logic [LW-1:0]            len_m1;
    logic                     idx_last;
    logic                     pidx_last;

    bol_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign full      = (r_len == LW'(CAPACITY));
    assign len_m1    = r_len - LW'(1);
    assign idx_last  = (LW'(r_idx) == len_m1);
    assign pidx_last = (LW'(r_pidx) == len_m1);

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_sum    = r_sum;
        n_act    = r_act;
        n_val    = r_val;
        n_idx    = r_idx;
        n_more   = r_more;
        n_pend   = 1'b0;
        n_pidx   = r_pidx;
        n_status = r_status;
        n_pos    = r_pos;

        n_ovalid  = r_ovalid && !i_m_tready;
        n_ostatus = r_ostatus;
        n_opos    = r_opos;
        n_ototal  = r_ototal;
        n_ocount  = r_ocount;

        rd_en   = 1'b0;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_act    = i_s_tuser;
                    n_val    = i_s_tdata;
                    n_status = bol_pkg::ST_OK;
                    n_pos    = '0;
                    n_state  = S_DONE;
                    unique case (i_s_tuser)
                        bol_pkg::ACT_APPEND: begin
                            if (full) begin
                                n_status = bol_pkg::ST_FULL;
                            end else begin
                                // Write straight at the tail slot
                                wr_en   = 1'b1;
                                wr_addr = r_len[AW-1:0];
                                wr_data = i_s_tdata;
                                n_len   = r_len + LW'(1);
                                n_sum   = r_sum + i_s_tdata;
                            end
                        end
                        bol_pkg::ACT_HEAD: begin
                            if (full) begin
                                n_status = bol_pkg::ST_FULL;
                            end else if (r_len == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = i_s_tdata;
                                n_len   = r_len + LW'(1);
                                n_sum   = r_sum + i_s_tdata;
                            end else begin
                                // Shift from the tail end downward
                                n_idx   = AW'(len_m1);
                                n_more  = 1'b1;
                                n_state = S_SHUP;
                            end
                        end
                        bol_pkg::ACT_SEARCH, bol_pkg::ACT_DELETE: begin
                            if (r_len == '0) begin
                                n_status = bol_pkg::ST_NOTFOUND;
                            end else begin
                                n_idx   = '0;
                                n_more  = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            // Sum and unused codes only report the state
                        end
                    endcase
                end
            end

            S_SHUP: begin
                rd_en  = r_more;
                n_pend = r_more;
                n_pidx = r_idx;
                if (r_more) begin
                    if (r_idx == '0) begin
                        n_more = 1'b0;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pidx + AW'(1);
                    wr_data = rd_data;
                end else if (!r_more) begin
                    // All entries moved: drop the new value at the head
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = r_val;
                    n_len   = r_len + LW'(1);
                    n_sum   = r_sum + r_val;
                    n_state = S_DONE;
                end
            end

            S_SCAN: begin
                rd_en  = r_more;
                n_pend = r_more;
                n_pidx = r_idx;
                if (r_more) begin
                    if (idx_last) begin
                        n_more = 1'b0;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
                if (r_pend) begin
                    if (rd_data == r_val) begin
                        // First match: drop the read already in flight
                        n_pend   = 1'b0;
                        n_more   = 1'b0;
                        n_pos    = LW'(r_pidx) + LW'(1);
                        n_status = bol_pkg::ST_OK;
                        n_state  = S_DONE;
                        if (r_act == bol_pkg::ACT_DELETE) begin
                            n_sum = r_sum - rd_data;
                            if (pidx_last) begin
                                n_len = len_m1;
                            end else begin
                                n_idx   = r_pidx + AW'(1);
                                n_more  = 1'b1;
                                n_state = S_SHDN;
                            end
                        end
                    end else if (!r_more) begin
                        n_status = bol_pkg::ST_NOTFOUND;
                        n_state  = S_DONE;
                    end
                end
            end

            S_SHDN: begin
                rd_en  = r_more;
                n_pend = r_more;
                n_pidx = r_idx;
                if (r_more) begin
                    if (idx_last) begin
                        n_more = 1'b0;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pidx - AW'(1);
                    wr_data = rd_data;
                end else if (!r_more) begin
                    n_len   = len_m1;
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_opos    = r_pos;
                    n_ototal  = r_sum;
                    n_ocount  = r_len;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_sum    <= '0;
            r_more   <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_sum    <= n_sum;
            r_more   <= n_more;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_status  <= n_status;
        r_pos     <= n_pos;
        r_ostatus <= n_ostatus;
        r_opos    <= n_opos;
        r_ototal  <= n_ototal;
        r_ocount  <= n_ocount;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tdata  = TDW'({r_ocount, r_ototal, r_opos});

`ifndef SYNTHESIS
    // The list never holds more than its capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("list length above capacity");

    // An accepted request always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // Walking states only run over a non-empty list
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHUP || r_state == S_SHDN) |-> (r_len != '0))
        else $error("entry walk on an empty list");
`endif

endmodule

>>> sim/tb_top.sv
// Self-checking bench for bounded_ordered_list: a directed request table and a random
// request stream, checked against a behavioral list model or typed table results.
// Depends on bol_pkg (action and status codes) and the bounded_ordered_list RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int CAPACITY    = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int M_W         = ((2 * CNT_W + 32 + 7) / 8) * 8;
    localparam int RAND_REQS   = 1750;
    localparam int CALM_REQS   = 200;     // tail of the run with no idling
    localparam int DRAIN_WAIT  = 40;      // quiet wait for stray results after the drain
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_N      = 10;

    // Action codes the block must ignore
    localparam bol_pkg::t_action ACT_SPARE_LO = 3'd5;
    localparam bol_pkg::t_action ACT_SPARE_HI = 3'd7;

    typedef struct {
        bol_pkg::t_status status;
        logic [CNT_W-1:0] position;
        bol_pkg::t_word   total;
        logic [CNT_W-1:0] count;
    } t_outcome;

    typedef struct {
        bol_pkg::t_action act;
        bol_pkg::t_word   val;
        bit               typed;      // expected result written into the table
        t_outcome         exp;
    } t_req_row;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [31:0]      i_s_tdata  = '0;     // value (signed)
    logic [2:0]       i_s_tuser  = '0;     // action
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [M_W-1:0]   o_m_tdata;           // position, total, entry_count, pad
    logic [1:0]       o_m_tuser;           // status

    // List model state
    bol_pkg::t_word   list_mem [CAPACITY];
    int unsigned      list_len = 0;
    bol_pkg::t_word   sum_reg  = '0;

    t_outcome         pending_q[$];        // results still owed by the block
    t_req_row         dir_rows[$];
    bol_pkg::t_word   value_pool [POOL_N];
    int unsigned      mismatch_cnt = 0;
    int unsigned      cycle_cnt    = 0;
    bit               calm_tail    = 1'b0; // no idling on either side
    bit               sink_busy    = 1'b0; // receiver in a stalling stretch
    int unsigned      sink_hold    = 0;

    bounded_ordered_list #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one request to the list model and return what the block must report.
    function automatic t_outcome apply_request(bol_pkg::t_action act,
                                               bol_pkg::t_word val);
        t_outcome res;
        int       hit;
        res.status   = bol_pkg::ST_OK;
        res.position = '0;
        hit = -1;
        case (act)
            bol_pkg::ACT_APPEND, bol_pkg::ACT_HEAD: begin
                if (list_len >= CAPACITY) begin
                    res.status = bol_pkg::ST_FULL;
                end else begin
                    if (act == bol_pkg::ACT_HEAD) begin
                        // shift everything one place toward the tail
                        for (int i = list_len; i > 0; i--)
                            list_mem[i] = list_mem[i - 1];
                        list_mem[0] = val;
                    end else begin
                        list_mem[list_len] = val;
                    end
                    list_len++;
                    sum_reg += val;
                end
            end
            bol_pkg::ACT_SEARCH, bol_pkg::ACT_DELETE: begin
                for (int i = 0; i < list_len; i++)
                    if (hit < 0 && list_mem[i] == val)
                        hit = i;
                if (hit < 0) begin
                    res.status = bol_pkg::ST_NOTFOUND;
                end else begin
                    res.position = CNT_W'(hit + 1);
                    if (act == bol_pkg::ACT_DELETE) begin
                        // close the gap left by the removed entry
                        sum_reg -= list_mem[hit];
                        for (int i = hit; i + 1 < list_len; i++)
                            list_mem[i] = list_mem[i + 1];
                        list_len--;
                    end
                end
            end
            default: ;
        endcase
        res.total = sum_reg;
        res.count = CNT_W'(list_len);
        return res;
    endfunction

    function automatic t_req_row mk_row(bol_pkg::t_action act, bol_pkg::t_word val,
                                        bit typed, bol_pkg::t_status st, int pos,
                                        bol_pkg::t_word tot, int cnt);
        t_req_row r;
        r.act          = act;
        r.val          = val;
        r.typed        = typed;
        r.exp.status   = st;
        r.exp.position = CNT_W'(pos);
        r.exp.total    = tot;
        r.exp.count    = CNT_W'(cnt);
        return r;
    endfunction

    // Values: mostly ones held in the list (so search/delete hit), then a small
    // pool with the extremes (duplicates), then anything at all.
    function automatic bol_pkg::t_word pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45 && list_len > 0)
            return list_mem[$urandom_range(list_len - 1)];
        if (r < 75)
            return value_pool[$urandom_range(POOL_N - 1)];
        return $urandom;
    endfunction

    function automatic bol_pkg::t_action pick_action(bit fill_bias);
        int unsigned r;
        int unsigned ins_pct;
        int unsigned del_pct;
        r       = $urandom_range(99);
        ins_pct = fill_bias ? 55 : 20;
        del_pct = fill_bias ? 15 : 45;
        if (r < ins_pct)
            return $urandom_range(1) ? bol_pkg::ACT_HEAD : bol_pkg::ACT_APPEND;
        if (r < ins_pct + del_pct)
            return bol_pkg::ACT_DELETE;
        if (r >= 97)
            return bol_pkg::t_action'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        if (r >= 92)
            return bol_pkg::ACT_SUM;
        return bol_pkg::ACT_SEARCH;
    endfunction

    // Present one request, hold it until accepted, log the expected result,
    // then drop valid for an idle burst if asked.
    task automatic send_request(bol_pkg::t_action act, bol_pkg::t_word val, bit typed,
                                t_outcome typed_exp, int unsigned gap);
        t_outcome exp;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= val;
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        exp = apply_request(act, val);
        pending_q.push_back(typed ? typed_exp : exp);
        if (gap > 0) begin
            // drive junk on the data lines while idle
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= $urandom;
            i_s_tuser  <= 3'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver: check each accepted result, then decide on back-pressure.
    always @(posedge i_clk) begin
        t_outcome         exp;
        logic [CNT_W-1:0] got_pos;
        bol_pkg::t_word   got_tot;
        logic [CNT_W-1:0] got_cnt;
        got_pos = o_m_tdata[CNT_W-1:0];
        got_tot = o_m_tdata[CNT_W +: 32];
        got_cnt = o_m_tdata[CNT_W + 32 +: CNT_W];
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d tdata %h",
                         $time, o_m_tuser, o_m_tdata);
                mismatch_cnt++;
            end else begin
                exp = pending_q.pop_front();
                if (o_m_tuser !== exp.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp.status, o_m_tuser);
                    mismatch_cnt++;
                end
                if (got_pos !== exp.position) begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, exp.position, got_pos);
                    mismatch_cnt++;
                end
                if (got_tot !== exp.total) begin
                    $display("%0t: total expected %h actual %h",
                             $time, exp.total, got_tot);
                    mismatch_cnt++;
                end
                if (got_cnt !== exp.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, exp.count, got_cnt);
                    mismatch_cnt++;
                end
            end
        end

        // Stall in bursts of random length; flip between stalling and
        // streaming stretches now and then.
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (calm_tail) begin
            i_m_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            i_m_tready <= 1'b0;
            sink_hold  <= sink_hold - 1;
        end else begin
            if ($urandom_range(63) == 0)
                sink_busy <= !sink_busy;
            if (sink_busy && $urandom_range(3) == 0) begin
                i_m_tready <= 1'b0;
                sink_hold  <= $urandom_range(11);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_outcome         none;
        t_req_row         row;
        bol_pkg::t_action act;
        bol_pkg::t_word   val;
        bit               fill_bias;
        bit               src_busy;
        int unsigned      gap;

        none = '{bol_pkg::ST_OK, '0, '0, '0};

        value_pool[0] = 32'sh0000_0000;
        value_pool[1] = 32'sh0000_0001;
        value_pool[2] = 32'shFFFF_FFFF;
        value_pool[3] = 32'sh7FFF_FFFF;
        value_pool[4] = 32'sh8000_0000;
        for (int i = 5; i < POOL_N; i++)
            value_pool[i] = $urandom;

        // Directed table, starting from the empty list. Typed rows hold
        // results that follow from reset, extremes and refusals directly.
        dir_rows.push_back(mk_row(bol_pkg::ACT_SUM,    32'sd0,  1, bol_pkg::ST_OK,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(bol_pkg::ACT_SEARCH, 32'sd5,  1, bol_pkg::ST_NOTFOUND,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(bol_pkg::ACT_DELETE, -32'sd5, 1, bol_pkg::ST_NOTFOUND,
                                  0, 0, 0));
        dir_rows.push_back(mk_row(bol_pkg::ACT_APPEND, 32'sh7FFF_FFFF, 1, bol_pkg::ST_OK,
                                  0, 32'sh7FFF_FFFF, 1));
        dir_rows.push_back(mk_row(bol_pkg::ACT_HEAD,   32'sh8000_0000, 1, bol_pkg::ST_OK,
                                  0, 32'shFFFF_FFFF, 2));
        dir_rows.push_back(mk_row(bol_pkg::ACT_SEARCH, 32'sh7FFF_FFFF, 1, bol_pkg::ST_OK,
                                  2, 32'shFFFF_FFFF, 2));
        // unused codes: no change, current state reported
        dir_rows.push_back(mk_row(ACT_SPARE_LO, 32'shFFFF_FFFF, 1, bol_pkg::ST_OK, 0,
                                  32'shFFFF_FFFF, 2));
        dir_rows.push_back(mk_row(ACT_SPARE_HI, 32'sh5555_5555, 1, bol_pkg::ST_OK, 0,
                                  32'shFFFF_FFFF, 2));
        // fill with cancelling pairs so the sum stays put
        for (int k = 1; k <= 7; k++) begin
            dir_rows.push_back(mk_row(bol_pkg::ACT_APPEND, k,  0, bol_pkg::ST_OK,
                                      0, 0, 0));
            dir_rows.push_back(mk_row(bol_pkg::ACT_HEAD,   -k, 0, bol_pkg::ST_OK,
                                      0, 0, 0));
        end
        // list full: both inserts refused
        dir_rows.push_back(mk_row(bol_pkg::ACT_APPEND, 32'sh1234_5678, 1, bol_pkg::ST_FULL,
                                  0, 32'shFFFF_FFFF, CAPACITY));
        dir_rows.push_back(mk_row(bol_pkg::ACT_HEAD,   32'sh0000_0000, 1, bol_pkg::ST_FULL,
                                  0, 32'shFFFF_FFFF, CAPACITY));
        dir_rows.push_back(mk_row(bol_pkg::ACT_DELETE, 32'sh8000_0000, 0, bol_pkg::ST_OK,
                                  0, 0, 0));

        // Hold reset, then release
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_request(row.act, row.val, row.typed, row.exp,
                         $urandom_range(3) == 0 ? $urandom_range(1, 12) : 0);
        end

        // Random requests: fill/drain phases keep the length wandering
        // between empty and full.
        fill_bias = 1'b1;
        src_busy  = 1'b1;
        for (int n = 0; n < RAND_REQS; n++) begin
            if ($urandom_range(39) == 0)
                fill_bias = !fill_bias;
            if ($urandom_range(47) == 0)
                src_busy = !src_busy;
            if (n == RAND_REQS - CALM_REQS)
                calm_tail = 1'b1;
            act = pick_action(fill_bias);
            val = pick_value();
            gap = (!calm_tail && src_busy && $urandom_range(3) == 0) ?
                  $urandom_range(1, 12) : 0;
            send_request(act, val, 1'b0, none, gap);
        end
        i_s_tvalid <= 1'b0;

        // Drain: wait for every owed result, then watch for strays
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
